// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the keyboard matrix RTL.
// Users must have clk and rst_n in scope; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define AKM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("akm assertion failed");

// Same-cycle implication.
`define AKM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("akm assertion failed");

// Next-cycle implication.
`define AKM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("akm assertion failed");

`endif

// ----- rtl/akm_pkg.sv -----
// Types, constants and key ROM for the ASCII keyboard matrix scanner.
// No dependencies.
package akm_pkg;

  typedef enum logic {
    REQ_SELECT = 1'b0,
    REQ_READ   = 1'b1
  } akm_req_t;

  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_KEY  = 2'd1;
  localparam logic [1:0] PHASE_REL  = 2'd2;

  localparam logic [7:0] KmNone      = 8'hFF;
  localparam logic [7:0] KmShift     = 8'h60;
  localparam logic [7:0] KmCtrl      = 8'h61;
  localparam logic [6:0] KmCtrlLimit = 7'h20;

  localparam logic [7:0] KmRom [0:127] = '{
    8'hFF, 8'hFF, 8'h38, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'h75, 8'h73, 8'hFF, 8'hFF, 8'hFF, 8'h77, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
    8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h72, 8'hFF, 8'hFF, 8'hFF,
    8'h88, 8'h09, 8'h28, 8'h0B, 8'h0C, 8'h0D, 8'h0F, 8'h20,
    8'h19, 8'h08, 8'h18, 8'h1B, 8'h22, 8'h12, 8'h23, 8'h24,
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h10, 8'h11, 8'h1F, 8'h17, 8'h2A, 8'h13, 8'h2B, 8'h2C,
    8'h0A, 8'h2E, 8'h2F, 8'h38, 8'h39, 8'h3A, 8'h3B, 8'h3C,
    8'h3D, 8'h3E, 8'h3F, 8'h48, 8'h49, 8'h4A, 8'h4B, 8'h4C,
    8'h4D, 8'h4E, 8'h4F, 8'h58, 8'h59, 8'h5A, 8'h5B, 8'h5C,
    8'h5D, 8'h5E, 8'h5F, 8'h15, 8'h14, 8'h16, 8'h0E, 8'h1A,
    8'h21, 8'h26, 8'h27, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34,
    8'h35, 8'h36, 8'h37, 8'h40, 8'h41, 8'h42, 8'h43, 8'h44,
    8'h45, 8'h46, 8'h47, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h1D, 8'h1C, 8'h1E, 8'h29, 8'h83
  };

  typedef struct packed {
    akm_req_t   req_type;
    logic [3:0] row_select;
    logic       rx_ready;
    logic [7:0] rx_char;
  } akm_item_t;

  typedef struct packed {
    logic       has_result;
    logic [7:0] column_bits;
    logic       take_char;
    logic [3:0] row_nxt;
    logic [1:0] phase_nxt;
  } akm_step_t;

  function automatic logic [3:0] code_row(input logic [7:0] code);
    return code[7:4];
  endfunction

  function automatic logic [7:0] code_bits(input logic [7:0] code);
    return ~(8'b1 << code[2:0]);
  endfunction

endpackage

// ----- rtl/akm_lookup.sv -----
// Combinational evaluation of one item: ROM lookup, row match, phase update.
// Depends on akm_pkg.
module akm_lookup
  import akm_pkg::*;
(
  input  akm_item_t  item,
  input  logic [3:0] scan_row,
  input  logic [1:0] phase,
  output akm_step_t  step
);

  logic [6:0] ch;
  logic [7:0] code;
  logic [7:0] mod_code;
  logic       shifted;

  assign ch       = item.rx_char[6:0];
  assign code     = KmRom[ch];
  assign mod_code = (ch < KmCtrlLimit) ? KmCtrl : KmShift;
  assign shifted  = code[3];

  always_comb begin
    step.has_result  = 1'b0;
    step.column_bits = KmNone;
    step.take_char   = 1'b0;
    step.row_nxt     = scan_row;
    step.phase_nxt   = phase;
    if (item.req_type == REQ_SELECT) begin
      step.row_nxt = item.row_select;
    end else begin
      step.has_result = 1'b1;
      if (item.rx_ready) begin
        priority if (code == KmNone) begin
          step.take_char = 1'b1;
        end else if (!shifted) begin
          if (scan_row == code_row(code)) begin
            step.column_bits = code_bits(code);
            step.take_char   = 1'b1;
          end
        end else if (phase == PHASE_IDLE && scan_row == code_row(mod_code)) begin
          step.phase_nxt   = PHASE_KEY;
          step.column_bits = code_bits(mod_code);
        end else if (phase == PHASE_KEY && scan_row == code_row(code)) begin
          step.phase_nxt   = PHASE_REL;
          step.column_bits = code_bits(code);
        end else if (phase == PHASE_REL && scan_row == code_row(mod_code)) begin
          step.phase_nxt   = PHASE_IDLE;
          step.column_bits = code_bits(mod_code);
          step.take_char   = 1'b1;
        end else begin
          step.phase_nxt = phase;
        end
      end
    end
  end

endmodule

// ----- rtl/ascii_to_keyboard_matrix_scanner_core.sv -----
// Top level of the ASCII keyboard matrix scanner: input register, state, result register.
// Depends on akm_pkg, akm_lookup and assert_macros.svh.
//
// Usage: the host sends items on the in_ channel (valid/ready). A select item
// (req_type 0) stores the scanned row and gives no result. A read item
// (req_type 1) gives one result on the out_ channel: the active-low column
// bits of the current row and take_char, which tells the receiver to drop
// the pending character.
// An accepted item is held in the input register and evaluated there; its
// result enters the result register once the output register is free.
// Throughput: one item per cycle while results are taken; the path is one ROM
// read plus a row compare between the input register and the result register.
// Reset (rst_n low, synchronous) clears the scanned row, the shift phase and
// both valid flags. When the receiver holds out_ready low, the result stays
// in the output register; one more item waits in the input register, and
// in_ready falls only when a read item is blocked behind the held result.
// Select items still pass while a result is held.
module ascii_to_keyboard_matrix_scanner_core
  import akm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_req_type,
  input  logic [3:0] in_row_select,
  input  logic       in_rx_ready,
  input  logic [7:0] in_rx_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_column_bits,
  output logic       out_take_char
);

  `include "assert_macros.svh"

  akm_item_t  item_r;
  logic       item_valid_r;
  logic [3:0] scan_row_r;
  logic [1:0] phase_r;
  logic       out_valid_r;
  logic [7:0] out_bits_r;
  logic       out_take_r;

  akm_step_t  step;
  logic       out_free;
  logic       proc;
  logic       proc_rd;

  akm_lookup u_lookup (
    .item     (item_r),
    .scan_row (scan_row_r),
    .phase    (phase_r),
    .step     (step)
  );

  assign out_free = !out_valid_r || out_ready;
  assign proc     = item_valid_r && (!step.has_result || out_free);
  assign proc_rd  = proc && step.has_result;
  assign in_ready = !item_valid_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      scan_row_r   <= 4'd0;
      phase_r      <= PHASE_IDLE;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (proc) begin
        scan_row_r <= step.row_nxt;
        phase_r    <= step.phase_nxt;
      end
      if (proc_rd) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r.req_type   <= akm_req_t'(in_req_type);
      item_r.row_select <= in_row_select;
      item_r.rx_ready   <= in_rx_ready;
      item_r.rx_char    <= in_rx_char;
    end
    if (proc_rd) begin
      out_bits_r <= step.column_bits;
      out_take_r <= step.take_char;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_column_bits = out_bits_r;
  assign out_take_char   = out_take_r;

  `AKM_ASSERT(a_phase_legal, phase_r != 2'd3)
  `AKM_ASSERT_NXT(a_read_gives_result, proc_rd, out_valid_r)
  `AKM_ASSERT_IMP(a_no_overwrite, out_valid_r && !out_ready, !proc_rd)
  `AKM_ASSERT_NXT(a_phase_only_on_read, !proc_rd, $stable(phase_r))

endmodule
